[rtl/core/krt_pkg.sv]
package krt_pkg;

    // Default sizing
    localparam int DEPTH_DEF      = 16;
    localparam int NAME_BYTES_DEF = 8;

    // Fixed field widths
    localparam int KEY_W    = 32;
    localparam int NAME_W   = 64;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;
    localparam int CAP_W    = 5;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_DELETE = 2'd1,
        OP_UPDATE = 2'd2,
        OP_GET    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_DUP       = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_SAME      = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

    // Classified request passed from front to back
    typedef struct packed {
        op_t                op;
        logic [KEY_W-1:0]   key;
        logic [KEY_W-1:0]   new_key;
        logic [NAME_W-1:0]  name;
        logic               same_key;
    } req_t;

endpackage

[rtl/core/krt_ram.sv]
module krt_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/krt_front.sv]
module krt_front #(
    parameter int NAME_BYTES = krt_pkg::NAME_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  op,
    input  logic [krt_pkg::KEY_W-1:0]   key,
    input  logic [krt_pkg::KEY_W-1:0]   new_key,
    input  logic [krt_pkg::NAME_W-1:0]  name_word,
    output logic                        req_valid,
    input  logic                        req_ready,
    output krt_pkg::req_t               req
);

    localparam int NW = NAME_BYTES * 8;
    localparam logic [krt_pkg::NAME_W-1:0] NAME_MASK =
        {krt_pkg::NAME_W{1'b1}} >> (krt_pkg::NAME_W - NW);

    krt_pkg::req_t q_reg [2];
    krt_pkg::req_t in_req;
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    fill_reg, fill_next;
    logic          push, pop;

    // Classify the incoming request
    always_comb
    begin
        in_req.op       = krt_pkg::op_t'(op);
        in_req.key      = key;
        in_req.new_key  = new_key;
        in_req.name     = name_word & NAME_MASK;
        in_req.same_key = (key == new_key);
    end

    assign in_ready  = (fill_reg != 2'd2);
    assign req_valid = (fill_reg != 2'd0);
    assign req       = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = req_valid && req_ready;

    // Advance queue pointers
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Hold queued requests
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_req;
        end
    end

endmodule

[rtl/core/krt_back.sv]
module krt_back #(
    parameter int DEPTH      = krt_pkg::DEPTH_DEF,
    parameter int NAME_BYTES = krt_pkg::NAME_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  krt_pkg::req_t                 req,
    input  logic                          capacity_we,
    input  logic [krt_pkg::CAP_W-1:0]     capacity_wdata,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [krt_pkg::STATUS_W-1:0]  status,
    output logic [krt_pkg::KEY_W-1:0]     found_key,
    output logic [krt_pkg::NAME_W-1:0]    found_name,
    output logic [krt_pkg::COUNT_W-1:0]   count
);

    localparam int NW  = NAME_BYTES * 8;
    localparam int RW  = krt_pkg::KEY_W + NW;
    localparam int IW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int CPW = (CW > krt_pkg::CAP_W) ? CW : krt_pkg::CAP_W;
    localparam int CAP_RST = (DEPTH < 16) ? DEPTH : 16;

    krt_pkg::state_t  state_reg, state_next;
    krt_pkg::req_t    cur_reg, cur_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    ptr_reg, ptr_next;
    logic             dv_reg, dv_next;
    logic [IW-1:0]    didx_reg, didx_next;
    logic             found_reg, found_next;
    logic [krt_pkg::KEY_W-1:0] fkey_reg, fkey_next;
    logic [NW-1:0]    fname_reg, fname_next;
    logic [CPW-1:0]   cap_reg;
    logic [CPW-1:0]   cap_wr;

    logic                         ov_reg, ov_next;
    krt_pkg::status_t             st_reg, st_next;
    logic [krt_pkg::KEY_W-1:0]    okey_reg, okey_next;
    logic [krt_pkg::NAME_W-1:0]   oname_reg, oname_next;
    logic [CW-1:0]                ocount_reg, ocount_next;

    logic             ram_we, ram_re;
    logic [IW-1:0]    ram_waddr, ram_raddr;
    logic [RW-1:0]    ram_wdata, ram_rdata;
    logic [krt_pkg::KEY_W-1:0] rd_key;
    logic             rd_match;
    logic             full;

    krt_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH),
        .AW    (IW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_key   = ram_rdata[RW-1:NW];
    assign rd_match = dv_reg && (rd_key == cur_reg.key);
    assign full     = (CPW'(count_reg) >= cap_reg);
    assign cap_wr   = CPW'(capacity_wdata);

    // Saturate capacity to the table depth
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CPW'(CAP_RST);
        end
        else if (capacity_we)
        begin
            cap_reg <= (cap_wr > CPW'(DEPTH)) ? CPW'(DEPTH) : cap_wr;
        end
    end

    // Sequencer: scan records, rewrite or compact in flight, then report; an add appends its record on report
    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        dv_next     = 1'b0;
        didx_next   = didx_reg;
        found_next  = found_reg;
        fkey_next   = fkey_reg;
        fname_next  = fname_reg;
        ov_next     = ov_reg && !out_ready;
        st_next     = st_reg;
        okey_next   = okey_reg;
        oname_next  = oname_reg;
        ocount_next = ocount_reg;
        req_ready   = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = ptr_reg[IW-1:0];
        ram_we      = 1'b0;
        ram_waddr   = didx_reg;
        ram_wdata   = ram_rdata;

        // Process read data returning from the table
        if (dv_reg)
        begin
            if (rd_match && !found_reg)
            begin
                found_next = 1'b1;
                fkey_next  = rd_key;
                fname_next = ram_rdata[NW-1:0];
            end
            if (cur_reg.op == krt_pkg::OP_UPDATE && rd_match && !cur_reg.same_key)
            begin
                ram_we    = 1'b1;
                ram_waddr = didx_reg;
                ram_wdata = {cur_reg.new_key, cur_reg.name[NW-1:0]};
            end
            else if (cur_reg.op == krt_pkg::OP_DELETE && found_reg)
            begin
                ram_we    = 1'b1;
                ram_waddr = didx_reg - IW'(1);
                ram_wdata = ram_rdata;
            end
        end

        unique case (state_reg)
            krt_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cur_next   = req;
                    ptr_next   = '0;
                    found_next = 1'b0;
                    fkey_next  = '0;
                    fname_next = '0;
                    state_next = (count_reg == '0) ? krt_pkg::S_FINISH : krt_pkg::S_SCAN;
                end
            end
            krt_pkg::S_SCAN:
            begin
                ram_re    = 1'b1;
                dv_next   = 1'b1;
                didx_next = ptr_reg[IW-1:0];
                ptr_next  = ptr_reg + CW'(1);
                if (ptr_reg == count_reg - CW'(1))
                begin
                    state_next = krt_pkg::S_DRAIN;
                end
            end
            krt_pkg::S_DRAIN:
            begin
                state_next = krt_pkg::S_FINISH;
            end
            krt_pkg::S_FINISH:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    okey_next  = '0;
                    oname_next = '0;
                    st_next    = krt_pkg::ST_OK;
                    case (cur_reg.op)
                        krt_pkg::OP_ADD:
                        begin
                            if (full)
                            begin
                                st_next = krt_pkg::ST_FULL;
                            end
                            else if (found_reg)
                            begin
                                st_next = krt_pkg::ST_DUP;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[IW-1:0];
                                ram_wdata  = {cur_reg.key, cur_reg.name[NW-1:0]};
                                count_next = count_reg + CW'(1);
                            end
                        end
                        krt_pkg::OP_DELETE:
                        begin
                            if (found_reg)
                            begin
                                count_next = count_reg - CW'(1);
                            end
                            else
                            begin
                                st_next = krt_pkg::ST_NOT_FOUND;
                            end
                        end
                        krt_pkg::OP_UPDATE:
                        begin
                            if (!found_reg)
                            begin
                                st_next = krt_pkg::ST_NOT_FOUND;
                            end
                            else if (cur_reg.same_key)
                            begin
                                st_next = krt_pkg::ST_SAME;
                            end
                        end
                        default:
                        begin
                            if (found_reg)
                            begin
                                okey_next  = fkey_reg;
                                oname_next = krt_pkg::NAME_W'(fname_reg);
                            end
                            else
                            begin
                                st_next = krt_pkg::ST_NOT_FOUND;
                            end
                        end
                    endcase
                    ocount_next = count_next;
                    state_next  = krt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = krt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= krt_pkg::S_IDLE;
            count_reg <= '0;
            dv_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            dv_reg    <= dv_next;
            ov_reg    <= ov_next;
        end
    end

    // Hold working and result payload
    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        ptr_reg    <= ptr_next;
        didx_reg   <= didx_next;
        found_reg  <= found_next;
        fkey_reg   <= fkey_next;
        fname_reg  <= fname_next;
        st_reg     <= st_next;
        okey_reg   <= okey_next;
        oname_reg  <= oname_next;
        ocount_reg <= ocount_next;
    end

    assign out_valid  = ov_reg;
    assign status     = st_reg;
    assign found_key  = okey_reg;
    assign found_name = oname_reg;
    assign count      = krt_pkg::COUNT_W'(ocount_reg);

endmodule

[rtl/core/keyed_record_table_unit.sv]
// The back sequencer scans the stored records through the single read port, one record
// a cycle, and takes a new request only after the previous result has been loaded into
// the result register; on an empty table the scan is skipped.
// Delete compaction and update rewrites ride on the same scan.
// Reset: asynchronous, active low; table empty, capacity 16 (or DEPTH if smaller),
// queue and result register empty. Record storage is not cleared.
module keyed_record_table_unit #(
    parameter int DEPTH      = krt_pkg::DEPTH_DEF,
    parameter int NAME_BYTES = krt_pkg::NAME_BYTES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          op,
    input  logic signed [krt_pkg::KEY_W-1:0]    key,
    input  logic signed [krt_pkg::KEY_W-1:0]    new_key,
    input  logic [krt_pkg::NAME_W-1:0]          name_word,
    input  logic                                capacity_we,
    input  logic [krt_pkg::CAP_W-1:0]           capacity_wdata,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [krt_pkg::STATUS_W-1:0]        status,
    output logic signed [krt_pkg::KEY_W-1:0]    found_key,
    output logic [krt_pkg::NAME_W-1:0]          found_name,
    output logic [krt_pkg::COUNT_W-1:0]         count
);

    logic          req_valid;
    logic          req_ready;
    krt_pkg::req_t req;

    krt_front #(
        .NAME_BYTES (NAME_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .key       (key),
        .new_key   (new_key),
        .name_word (name_word),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req)
    );

    krt_back #(
        .DEPTH      (DEPTH),
        .NAME_BYTES (NAME_BYTES)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req            (req),
        .capacity_we    (capacity_we),
        .capacity_wdata (capacity_wdata),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .found_key      (found_key),
        .found_name     (found_name),
        .count          (count)
    );

endmodule

[rtl/core/krt_checker.sv]
module krt_checker #(
    parameter int DEPTH = krt_pkg::DEPTH_DEF
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [krt_pkg::STATUS_W-1:0]       status,
    input logic [krt_pkg::KEY_W-1:0]          found_key,
    input logic [krt_pkg::NAME_W-1:0]         found_name,
    input logic [krt_pkg::COUNT_W-1:0]        count
);

    // A stalled result holds its status and count
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(count))
        else $error("result changed while stalled");

    // Status codes stay within the defined set
    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= krt_pkg::ST_SAME))
        else $error("illegal status code");

    // Only a successful lookup returns a record
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != krt_pkg::ST_OK |-> found_key == '0 && found_name == '0)
        else $error("record returned on failure");

    // Record count never exceeds the table depth (checked for depths up to 31)
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(count) <= DEPTH) || (DEPTH > 31))
        else $error("count beyond depth");

endmodule

bind keyed_record_table_unit krt_checker #(
    .DEPTH (DEPTH)
) u_krt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .found_key  (found_key),
    .found_name (found_name),
    .count      (count)
);

[tb/sv/keyed_record_table_unit_tb.sv]
module keyed_record_table_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import krt_pkg::*;

    localparam int TABLE_DEPTH = DEPTH_DEF;
    localparam logic [NAME_W-1:0] NAME_MASK = {NAME_W{1'b1}} >> (NAME_W - 8 * NAME_BYTES_DEF);

    // One expected result of the table
    typedef struct {
        status_t           status;
        logic [KEY_W-1:0]  found_key;
        logic [NAME_W-1:0] found_name;
        logic [COUNT_W-1:0] count;
    } table_answer_t;

    logic                     clk            = 1'b0;
    logic                     rst_n          = 1'b0;
    logic                     in_valid       = 1'b0;
    logic                     in_ready;
    logic [1:0]               op             = OP_ADD;
    logic signed [KEY_W-1:0]  key            = '0;
    logic signed [KEY_W-1:0]  new_key        = '0;
    logic [NAME_W-1:0]        name_word      = '0;
    logic                     capacity_we    = 1'b0;
    logic [CAP_W-1:0]         capacity_wdata = '0;
    logic                     out_valid;
    logic                     out_ready      = 1'b0;
    logic [STATUS_W-1:0]      status;
    logic signed [KEY_W-1:0]  found_key;
    logic [NAME_W-1:0]        found_name;
    logic [COUNT_W-1:0]       count;

    // Shadow copy of the table and its capacity register
    logic [KEY_W-1:0]   shadow_keys [TABLE_DEPTH];
    logic [NAME_W-1:0]  shadow_names [TABLE_DEPTH];
    int unsigned        shadow_count;
    int unsigned        shadow_cap;

    table_answer_t      answer_q [$];
    table_answer_t      head_answer;

    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 mismatches;
    int                 requests_sent;
    int                 answers_checked;
    int                 status_seen [5];

    keyed_record_table_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .key            (key),
        .new_key        (new_key),
        .name_word      (name_word),
        .capacity_we    (capacity_we),
        .capacity_wdata (capacity_wdata),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .found_key      (found_key),
        .found_name     (found_name),
        .count          (count)
    );

    always #2 clk = ~clk;

    // Apply one request to the shadow table and return the result it should give
    function automatic table_answer_t predict_answer(op_t req_op, logic [KEY_W-1:0] req_key,
                                                     logic [KEY_W-1:0] req_new_key,
                                                     logic [NAME_W-1:0] req_name);
        table_answer_t ans;
        int            pos;
        int unsigned   i;
        ans.status     = ST_OK;
        ans.found_key  = '0;
        ans.found_name = '0;
        pos = -1;
        for (i = 0; i < shadow_count; i++)
        begin
            if (pos < 0 && shadow_keys[i] == req_key)
                pos = i;
        end
        case (req_op)
            OP_ADD:
            begin
                if (shadow_count >= shadow_cap || shadow_count >= TABLE_DEPTH)
                    ans.status = ST_FULL;
                else if (pos >= 0)
                    ans.status = ST_DUP;
                else
                begin
                    shadow_keys[shadow_count]  = req_key;
                    shadow_names[shadow_count] = req_name & NAME_MASK;
                    shadow_count++;
                end
            end
            OP_DELETE:
            begin
                if (pos < 0)
                    ans.status = ST_NOT_FOUND;
                else
                begin
                    // Close the gap left by the removed record
                    for (i = pos; i + 1 < shadow_count; i++)
                    begin
                        shadow_keys[i]  = shadow_keys[i + 1];
                        shadow_names[i] = shadow_names[i + 1];
                    end
                    shadow_count--;
                end
            end
            OP_UPDATE:
            begin
                if (pos < 0)
                    ans.status = ST_NOT_FOUND;
                else if (req_new_key == req_key)
                    ans.status = ST_SAME;
                else
                begin
                    // Rewrite every record holding the old key
                    for (i = pos; i < shadow_count; i++)
                    begin
                        if (shadow_keys[i] == req_key)
                        begin
                            shadow_keys[i]  = req_new_key;
                            shadow_names[i] = req_name & NAME_MASK;
                        end
                    end
                end
            end
            default:
            begin
                if (pos < 0)
                    ans.status = ST_NOT_FOUND;
                else
                begin
                    ans.found_key  = shadow_keys[pos];
                    ans.found_name = shadow_names[pos];
                end
            end
        endcase
        ans.count = shadow_count[COUNT_W-1:0];
        return ans;
    endfunction

    // Favour keys already in the table so that matches are common
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 55 && shadow_count > 0)
            return shadow_keys[$urandom_range(shadow_count - 1)];
        else if (r < 80)
        begin
            case ($urandom_range(5))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                3: return 32'hFFFF_FFFF;
                4: return 32'h0000_0001;
                default: return $urandom_range(15);
            endcase
        end
        return $urandom;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Present one request, hold it until accepted, then record its expected result
    task automatic send_request(input op_t req_op, input logic [KEY_W-1:0] req_key,
                                input logic [KEY_W-1:0] req_new_key,
                                input logic [NAME_W-1:0] req_name);
        table_answer_t ans;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        op        <= req_op;
        key       <= req_key;
        new_key   <= req_new_key;
        name_word <= req_name;
        do
            @(posedge clk);
        while (!in_ready);
        ans = predict_answer(req_op, req_key, req_new_key, req_name);
        status_seen[ans.status]++;
        answer_q.push_back(ans);
        requests_sent++;
    endtask

    // Drop valid and hold until every outstanding request has been answered
    task automatic wait_table_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (answer_q.size() != 0);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        wait_table_idle();
        capacity_we    <= 1'b1;
        capacity_wdata <= value;
        @(posedge clk);
        capacity_we <= 1'b0;
        shadow_cap = (value > TABLE_DEPTH) ? TABLE_DEPTH : value;
    endtask

    // Check each result against the oldest expectation; randomise back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (answer_q.size() == 0)
                    report_mismatch("result with no request outstanding");
                else
                begin
                    head_answer = answer_q.pop_front();
                    answers_checked++;
                    if (status !== head_answer.status)
                        report_mismatch($sformatf("status got %0d exp %0d",
                                                  status, head_answer.status));
                    if (found_key !== head_answer.found_key)
                        report_mismatch($sformatf("found_key got %h exp %h",
                                                  found_key, head_answer.found_key));
                    if (found_name !== head_answer.found_name)
                        report_mismatch($sformatf("found_name got %h exp %h",
                                                  found_name, head_answer.found_name));
                    if (count !== head_answer.count)
                        report_mismatch($sformatf("count got %0d exp %0d",
                                                  count, head_answer.count));
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Lookups on an empty table
    task automatic test_empty_table();
        send_request(OP_GET, 32'h0000_0000, 32'h0, {$urandom, $urandom});
        send_request(OP_DELETE, 32'h8000_0000, 32'h0, {$urandom, $urandom});
        send_request(OP_UPDATE, 32'h7FFF_FFFF, 32'h1, {$urandom, $urandom});
    endtask

    // Extreme keys and names, duplicate add
    task automatic test_add_get_extremes();
        send_request(OP_ADD, 32'h8000_0000, 32'h0, 64'h0);
        send_request(OP_ADD, 32'h7FFF_FFFF, 32'h0, {NAME_W{1'b1}});
        send_request(OP_ADD, 32'h8000_0000, 32'h0, {$urandom, $urandom});
        send_request(OP_ADD, 32'h0000_0000, 32'h0, {$urandom, $urandom});
        send_request(OP_GET, 32'h8000_0000, 32'h0, 64'h0);
        send_request(OP_GET, 32'h7FFF_FFFF, 32'h0, 64'h0);
    endtask

    // Update with no match, to the same key, and making duplicates
    task automatic test_update_cases();
        send_request(OP_UPDATE, 32'd12345, 32'd1, {$urandom, $urandom});
        send_request(OP_UPDATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, {$urandom, $urandom});
        send_request(OP_UPDATE, 32'h0000_0000, 32'h8000_0000, {$urandom, $urandom});
        send_request(OP_GET, 32'h8000_0000, 32'h0, 64'h0);
        send_request(OP_UPDATE, 32'h8000_0000, 32'hFFFF_FFFF, {$urandom, $urandom});
        send_request(OP_GET, 32'hFFFF_FFFF, 32'h0, 64'h0);
    endtask

    // Delete the first of two equal keys, then a miss
    task automatic test_delete_shift();
        send_request(OP_DELETE, 32'hFFFF_FFFF, 32'h0, 64'h0);
        send_request(OP_GET, 32'hFFFF_FFFF, 32'h0, 64'h0);
        send_request(OP_DELETE, 32'h7FFF_FFFF, 32'h0, 64'h0);
        send_request(OP_DELETE, 32'd777, 32'h0, 64'h0);
    endtask

    // Capacity below the count, zero capacity, saturating write
    task automatic test_capacity_limits();
        send_request(OP_ADD, 32'd10, 32'h0, {$urandom, $urandom});
        send_request(OP_ADD, 32'd11, 32'h0, {$urandom, $urandom});
        write_capacity(5'd1);
        send_request(OP_ADD, 32'd12, 32'h0, {$urandom, $urandom});
        write_capacity(5'd0);
        send_request(OP_ADD, 32'd10, 32'h0, {$urandom, $urandom});
        send_request(OP_GET, 32'd10, 32'h0, 64'h0);
        write_capacity(5'd31);
        send_request(OP_ADD, 32'd12, 32'h0, {$urandom, $urandom});
    endtask

    // Mostly well-formed traffic on live keys, with a full drain half way
    task automatic test_random_traffic(input int n_items, input int send_pct,
                                       input int recv_pct);
        int               n;
        int               r;
        op_t              req_op;
        logic [KEY_W-1:0] req_key;
        logic [KEY_W-1:0] req_new_key;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (n = 0; n < n_items; n++)
        begin
            if (n == n_items / 2)
                wait_table_idle();
            r = $urandom_range(99);
            req_op = (r < 40) ? OP_ADD : (r < 60) ? OP_DELETE : (r < 80) ? OP_UPDATE : OP_GET;
            req_key = pick_key();
            r = $urandom_range(99);
            req_new_key = (r < 20) ? req_key : (r < 50) ? pick_key() : $urandom;
            send_request(req_op, req_key, req_new_key, {$urandom, $urandom});
        end
    endtask

    initial
    begin
        send_idle_pct = 33;
        recv_idle_pct = 69;
        shadow_count  = 0;
        shadow_cap    = (16 > TABLE_DEPTH) ? TABLE_DEPTH : 16;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_add_get_extremes();
        test_update_cases();
        test_delete_shift();
        test_capacity_limits();

        test_random_traffic(300, 33, 69);
        write_capacity(5'd4);
        test_random_traffic(300, 69, 33);
        write_capacity(5'd16);
        test_random_traffic(300, 0, 0);

        // Let any stray result show up before closing
        wait_table_idle();
        repeat (24) @(posedge clk);

        $display("Covered %0d requests, %0d results checked, capacities 0, 1, 4 and 16.",
                 requests_sent, answers_checked);
        $display("Status mix: ok %0d, full %0d, duplicate %0d, not found %0d, same key %0d.",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_DUP],
                 status_seen[ST_NOT_FOUND], status_seen[ST_SAME]);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Timed out with %0d results outstanding", answer_q.size());
        $display("FAIL");
        $finish;
    end

endmodule
